>>> sv/cam_pkg.sv
// shared types, constants and table builders for the azimuth mean block
// no dependencies
package cam_pkg;

	localparam int MAX_GROUP    = 64;
	localparam int CORDIC_STEPS = 16;

	localparam int AZ_W    = 12;
	localparam int MEAN_W  = 20;
	localparam int TRIG_W  = 16;
	localparam int CNT_W   = $clog2(MAX_GROUP + 1);
	localparam int BSUM_W  = AZ_W + $clog2(MAX_GROUP);
	localparam int TSUM_W  = TRIG_W + $clog2(MAX_GROUP) + 1;
	localparam int NUM_W   = BSUM_W + 8;
	localparam int DCNT_W  = $clog2(NUM_W);
	localparam int CW      = TSUM_W + 19;
	localparam int STEP_W  = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
	localparam int ROM_DEPTH = 1024;
	localparam int HALF_TURN = 2048;
	localparam longint GAIN_Q30 = 64'd652032874;

	typedef struct packed {
		logic [AZ_W-1:0] azimuth;
		logic            last;
	} sample_t;

	typedef struct packed {
		logic [MEAN_W-1:0] mean_azimuth;
		logic              wrapped;
		logic              overflow;
	} result_t;

	// closed group handed from the front to the back
	typedef struct packed {
		logic [BSUM_W-1:0]        bin_sum;
		logic signed [TSUM_W-1:0] sine_sum;
		logic signed [TSUM_W-1:0] cosine_sum;
		logic [CNT_W-1:0]         count;
		logic                     wrap;
		logic                     overflow;
	} group_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} qstat_t;

	typedef logic [2*TRIG_W-1:0] sc_rom_t [ROM_DEPTH];

	// atan(2^-i), 2^32 units per turn
	function automatic logic [31:0] atan_at(input int i);
		logic [31:0] r;
		case (i)
			0: r = 32'd536870912;  1: r = 32'd316933406;  2: r = 32'd167458907;
			3: r = 32'd85004756;   4: r = 32'd42667331;   5: r = 32'd21354465;
			6: r = 32'd10679838;   7: r = 32'd5340245;    8: r = 32'd2670163;
			9: r = 32'd1335087;    10: r = 32'd667544;    11: r = 32'd333772;
			12: r = 32'd166886;    13: r = 32'd83443;     14: r = 32'd41722;
			15: r = 32'd20861;     16: r = 32'd10430;     17: r = 32'd5215;
			18: r = 32'd2608;      19: r = 32'd1304;      20: r = 32'd652;
			21: r = 32'd326;       22: r = 32'd163;       23: r = 32'd81;
			24: r = 32'd41;        25: r = 32'd20;        26: r = 32'd10;
			27: r = 32'd5;         28: r = 32'd3;         29: r = 32'd1;
			30: r = 32'd1;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [TRIG_W-1:0] to_q15(input longint v);
		longint r;
		r = (v + 64'sd16384) >>> 15;
		if (r > 64'sd32767) r = 64'sd32767;
		if (r < -64'sd32768) r = -64'sd32768;
		return TRIG_W'(r);
	endfunction

	// first-quadrant sine/cosine, rotation cordic at 2^30 scale
	function automatic sc_rom_t rom_build();
		sc_rom_t t;
		longint x, y, z, dx, dy;
		for (int b = 0; b < ROM_DEPTH; b++) begin
			x = GAIN_Q30;
			y = 0;
			z = longint'(b) << 20;
			for (int i = 0; i < 31; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x = x - dx; y = y + dy; z = z - longint'(atan_at(i));
				end else begin
					x = x + dx; y = y - dy; z = z + longint'(atan_at(i));
				end
			end
			t[b] = {to_q15(y), to_q15(x)};
		end
		return t;
	endfunction

endpackage

>>> sv/cam_front.sv
// front: sample register, sine/cosine rom and per-group accumulation
// depends on cam_pkg
module cam_front import cam_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    sample_valid,
	output logic    sample_stall,
	input  sample_t sample,
	input  qstat_t  qstat,
	output logic    push,
	output group_t  group
);
	localparam sc_rom_t SC_ROM = rom_build();

	logic                     valid_s1;
	logic [AZ_W-1:0]          az_s1;
	logic                     last_s1;
	logic [2*TRIG_W-1:0]      rom_s1;
	logic [AZ_W-1:0]          prev_q;
	logic                     wrap_q;
	logic                     ovf_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [BSUM_W-1:0]        bsum_q;
	logic signed [TSUM_W-1:0] ssum_q;
	logic signed [TSUM_W-1:0] csum_q;

	logic                     adv, take, accept, sat;
	logic signed [TRIG_W-1:0] s_b, c_b, s_v, c_v;
	logic signed [AZ_W:0]     diff;
	logic [AZ_W-1:0]          mag;
	group_t                   nxt;

	assign adv          = !(last_s1 && qstat.full);
	assign sample_stall = valid_s1 && !adv;
	assign accept       = sample_valid && !sample_stall;
	assign take         = valid_s1 && adv;
	assign sat          = (cnt_q >= CNT_W'(MAX_GROUP));

	always_comb begin
		s_b  = rom_s1[2*TRIG_W-1:TRIG_W];
		c_b  = rom_s1[TRIG_W-1:0];
		case (az_s1[AZ_W-1:AZ_W-2])
			2'd0:    begin s_v = s_b;  c_v = c_b;  end
			2'd1:    begin s_v = c_b;  c_v = -s_b; end
			2'd2:    begin s_v = -s_b; c_v = -c_b; end
			default: begin s_v = -c_b; c_v = s_b;  end
		endcase
		diff = $signed({1'b0, az_s1}) - $signed({1'b0, prev_q});
		mag  = diff[AZ_W] ? AZ_W'(-diff) : diff[AZ_W-1:0];
		nxt.bin_sum    = bsum_q;
		nxt.sine_sum   = ssum_q;
		nxt.cosine_sum = csum_q;
		nxt.count      = cnt_q;
		nxt.wrap       = wrap_q;
		nxt.overflow   = ovf_q;
		if (sat) begin
			nxt.overflow = 1'b1;
		end else begin
			if (cnt_q != '0 && {1'b0, mag} > (AZ_W+1)'(HALF_TURN)) nxt.wrap = 1'b1;
			nxt.bin_sum    = bsum_q + BSUM_W'(az_s1);
			nxt.sine_sum   = ssum_q + TSUM_W'(s_v);
			nxt.cosine_sum = csum_q + TSUM_W'(c_v);
			nxt.count      = cnt_q + CNT_W'(1);
		end
	end

	assign push  = take && last_s1;
	assign group = nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			az_s1   <= sample.azimuth;
			last_s1 <= sample.last;
			rom_s1  <= SC_ROM[sample.azimuth[AZ_W-3:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0; wrap_q <= 1'b0; ovf_q <= 1'b0; cnt_q <= '0;
			bsum_q <= '0; ssum_q <= '0; csum_q <= '0;
		end else if (take) begin
			if (last_s1) begin
				prev_q <= '0; wrap_q <= 1'b0; ovf_q <= 1'b0; cnt_q <= '0;
				bsum_q <= '0; ssum_q <= '0; csum_q <= '0;
			end else begin
				if (!sat) prev_q <= az_s1;
				wrap_q <= nxt.wrap; ovf_q <= nxt.overflow; cnt_q <= nxt.count;
				bsum_q <= nxt.bin_sum; ssum_q <= nxt.sine_sum; csum_q <= nxt.cosine_sum;
			end
		end
	end
endmodule

>>> sv/cam_queue.sv
// two-entry queue of closed groups between front and back
// depends on cam_pkg
module cam_queue import cam_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  group_t wr_group,
	input  logic   pop,
	output group_t rd_group,
	output qstat_t qstat
);
	group_t     mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign rd_group       = mem_q[rd_q];
	assign qstat.full     = (cnt_q == 2'd2);
	assign qstat.nonempty = (cnt_q != 2'd0);

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wr_group;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop)  rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

>>> sv/cam_back.sv
// back: restoring divider or vectoring cordic per group, result register
// depends on cam_pkg
module cam_back import cam_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  qstat_t  qstat,
	input  group_t  grp,
	output logic    pop,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DIV  = 4'b0010,
		S_ROT  = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t               state_q;
	logic [NUM_W-1:0]     num_q;
	logic [CNT_W-1:0]     den_q;
	logic [CNT_W-1:0]     rem_q;
	logic [DCNT_W-1:0]    dcnt_q;
	logic signed [CW-1:0] x_q, y_q;
	logic [31:0]          z_q;
	logic [STEP_W-1:0]    step_q;
	logic                 wrap_q, ovf_q;
	logic [MEAN_W-1:0]    mean_q;
	logic                 rv_q;
	result_t              res_q;

	logic [CNT_W-1:0]     n;
	logic [CNT_W:0]       trial;
	logic                 ge;
	logic signed [CW-1:0] xi, yi, dx, dy;
	logic [31:0]          at, zr;
	logic                 out_free;

	assign pop      = (state_q == S_IDLE) && qstat.nonempty;
	assign out_free = !rv_q || !result_stall;
	assign n        = (grp.count == '0) ? CNT_W'(1) : grp.count;
	assign trial    = {rem_q, num_q[NUM_W-1]};
	assign ge       = trial >= {1'b0, den_q};
	assign xi       = {{(CW-TSUM_W-16){grp.cosine_sum[TSUM_W-1]}}, grp.cosine_sum, 16'b0};
	assign yi       = {{(CW-TSUM_W-16){grp.sine_sum[TSUM_W-1]}}, grp.sine_sum, 16'b0};
	assign dx       = y_q >>> step_q;
	assign dy       = x_q >>> step_q;
	assign at       = atan_at(int'(step_q));
	assign zr       = z_q + 32'd2048;
	assign result_valid = rv_q;
	assign result       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rv_q    <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free) begin
				rv_q <= 1'b1;
			end else if (!result_stall) begin
				rv_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: if (qstat.nonempty) begin
					if (!grp.wrap) begin
						state_q <= S_DIV;
					end else if (grp.sine_sum == '0 && grp.cosine_sum == '0) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_ROT;
					end
				end
				S_DIV: if (dcnt_q == '0) state_q <= S_OUT;
				S_ROT: if (step_q == STEP_W'(CORDIC_STEPS - 1)) state_q <= S_OUT;
				S_OUT: if (out_free) begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (qstat.nonempty) begin
				wrap_q <= grp.wrap;
				ovf_q  <= grp.overflow;
				num_q  <= {grp.bin_sum, 8'b0} + NUM_W'(n >> 1);
				den_q  <= n;
				rem_q  <= '0;
				dcnt_q <= DCNT_W'(NUM_W - 1);
				step_q <= '0;
				mean_q <= '0;
				if (grp.cosine_sum[TSUM_W-1]) begin
					x_q <= -xi; y_q <= -yi; z_q <= 32'h8000_0000;
				end else begin
					x_q <= xi;  y_q <= yi;  z_q <= 32'h0;
				end
			end
			S_DIV: begin
				rem_q  <= ge ? CNT_W'(trial - {1'b0, den_q}) : trial[CNT_W-1:0];
				num_q  <= {num_q[NUM_W-2:0], ge};
				dcnt_q <= dcnt_q - DCNT_W'(1);
				if (dcnt_q == '0) mean_q <= {num_q[MEAN_W-2:0], ge};
			end
			S_ROT: begin
				if (!y_q[CW-1]) begin
					x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + at;
				end else begin
					x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - at;
				end
				step_q <= step_q + STEP_W'(1);
			end
			S_OUT: if (out_free) begin
				res_q.mean_azimuth <= (wrap_q && mean_q == '0 && z_q != '0) ? 
					zr[31:32-MEAN_W] : mean_q;
				res_q.wrapped      <= wrap_q;
				res_q.overflow     <= ovf_q;
			end
			default: ;
		endcase
	end
endmodule

>>> sv/circular_azimuth_mean.sv
// mean azimuth of groups of replies, by the divide path, the circular path or the zero vector
// path; a result waits in the result register while it is stalled
// samples enter one per cycle while the input is not stalled; groups queue two deep, and the
// back unit takes one group at a time, so short groups can stall the input
// arst_n clears all accumulators, the queue and the result valid flag
// depends on cam_pkg, cam_front, cam_queue, cam_back
module circular_azimuth_mean import cam_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    sample_valid,
	output logic    sample_stall,
	input  sample_t sample,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);
	// front to queue
	logic   push;
	group_t wr_group;
	// queue to back
	logic   pop;
	group_t rd_group;
	qstat_t qstat;

	// samples are registered, looked up in the sine/cosine rom and summed
	cam_front u_front (
		.clk, .arst_n, .sample_valid, .sample_stall, .sample,
		.qstat, .push, .group(wr_group)
	);

	// closed groups wait here while the back unit is busy
	cam_queue u_queue (
		.clk, .arst_n, .push, .wr_group, .pop, .rd_group, .qstat
	);

	// divide or atan2, then the result register
	cam_back u_back (
		.clk, .arst_n, .qstat, .grp(rd_group), .pop,
		.result_valid, .result_stall, .result
	);

`ifndef ASSERT_OFF
	// the front never closes a group into a full queue
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && qstat.full)) else $error("group pushed into full queue");

	// a linear mean can not exceed the largest bin
	a_mean_range: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.wrapped) |-> (result.mean_azimuth <= MEAN_W'(4095*256)))
		else $error("linear mean out of range");

	// input stalls only when the queue is full
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> qstat.full) else $error("input stalled without cause");
`endif
endmodule

>>> tb/circular_azimuth_mean_test.sv
// testbench for circular_azimuth_mean: directed and random groups of azimuth samples
// predicts each mean and flag set with its own arithmetic; depends on cam_pkg and the block
`timescale 1ns / 100ps

module circular_azimuth_mean_test import cam_pkg::*; ();

	localparam int WATCHDOG_LIMIT = 20000;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    sample_valid = 1'b0;
	logic    sample_stall;
	sample_t sample = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	circular_azimuth_mean DUT (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always #10 clk = ~clk;

	// first-quadrant sine and cosine in Q1.15, built once at time zero
	logic signed [15:0] quad_sine [1024];
	logic signed [15:0] quad_cosine [1024];

	// running group state of the predictor
	logic [11:0]        prev_bin;
	logic               jump_seen;
	int                 group_count;
	int                 group_bin_sum;
	int                 group_sine_sum;
	int                 group_cosine_sum;
	logic               dropped_seen;

	result_t expected_means [$];
	int      error_count = 0;
	int      idle_cycles = 0;
	int      burst_left = 0;
	int      stall_mode = 0;

	function automatic logic [31:0] arctan_step(input int i);
		logic [31:0] t [31] = '{
			32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
			32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
			32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
			32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
			32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1};
		return t[i];
	endfunction

	function automatic logic signed [15:0] round_q15(input longint v);
		longint r;
		r = (v + 64'sd16384) >>> 15;
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return 16'(r);
	endfunction

	task automatic build_trig();
		longint x, y, z, dx, dy;
		for (int b = 0; b < 1024; b++) begin
			x = 64'sd652032874;
			y = 0;
			z = longint'(b) << 20;
			for (int i = 0; i < 31; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= longint'(arctan_step(i));
				end else begin
					x += dx; y -= dy; z += longint'(arctan_step(i));
				end
			end
			quad_sine[b] = round_q15(y);
			quad_cosine[b] = round_q15(x);
		end
	endtask

	// vectoring cordic, angle at 2^32 per turn, rounded to 2^20
	function automatic logic [19:0] circular_angle(input int ys, input int xs);
		longint x, y, dx, dy;
		logic [31:0] z;
		logic [31:0] zr;
		if (xs == 0 && ys == 0) return '0;
		x = longint'(xs) * 65536;
		y = longint'(ys) * 65536;
		z = '0;
		if (x < 0) begin
			x = -x; y = -y; z = 32'h8000_0000;
		end
		for (int i = 0; i < CORDIC_STEPS && i < 31; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += arctan_step(i);
			end else begin
				x -= dx; y += dy; z -= arctan_step(i);
			end
		end
		zr = z + 32'd2048;
		return zr[31:12];
	endfunction

	task automatic clear_group();
		prev_bin = '0;
		jump_seen = 1'b0;
		group_count = 0;
		group_bin_sum = 0;
		group_sine_sum = 0;
		group_cosine_sum = 0;
		dropped_seen = 1'b0;
	endtask

	// fold one accepted sample into the group and queue the mean on last
	task automatic accumulate_sample(input sample_t s);
		int d;
		int sn, cs;
		result_t r;
		longint n;
		if (group_count >= MAX_GROUP) begin
			dropped_seen = 1'b1;
		end else begin
			if (group_count > 0) begin
				d = int'(s.azimuth) - int'(prev_bin);
				if (d < 0) d = -d;
				if (d > HALF_TURN) jump_seen = 1'b1;
			end
			sn = quad_sine[s.azimuth[9:0]];
			cs = quad_cosine[s.azimuth[9:0]];
			case (s.azimuth[11:10])
				2'd0: begin group_sine_sum += sn; group_cosine_sum += cs; end
				2'd1: begin group_sine_sum += cs; group_cosine_sum -= sn; end
				2'd2: begin group_sine_sum -= sn; group_cosine_sum -= cs; end
				default: begin group_sine_sum -= cs; group_cosine_sum += sn; end
			endcase
			group_bin_sum += int'(s.azimuth);
			prev_bin = s.azimuth;
			group_count++;
		end
		if (s.last) begin
			if (jump_seen) begin
				r.mean_azimuth = circular_angle(group_sine_sum, group_cosine_sum);
			end else begin
				n = (group_count > 0) ? group_count : 1;
				r.mean_azimuth = 20'(((longint'(group_bin_sum) << 8) + n / 2) / n);
			end
			r.wrapped = jump_seen;
			r.overflow = dropped_seen;
			expected_means = {expected_means, r};
			clear_group();
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// one transaction on the sample side; valid stays up into the next item within a burst
	task automatic send_sample(input logic [11:0] az, input logic lst);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				@(negedge clk);
				sample_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		sample_valid <= 1'b1;
		sample <= '{azimuth: az, last: lst};
		do @(posedge clk); while (sample_stall);
		accumulate_sample('{azimuth: az, last: lst});
	endtask

	task automatic send_group(input int len, input int center, input int spread);
		int v;
		for (int k = 0; k < len; k++) begin
			v = center + $urandom_range(0, 2 * spread) - spread;
			send_sample(12'(v), k == len - 1);
		end
	endtask

	task automatic apply_reset();
		clear_group();
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	endtask

	task automatic test_field_extremes();
		send_sample(12'd0, 1'b1);
		send_sample(12'd4095, 1'b1);
		send_sample(12'd4095, 1'b0);
		send_sample(12'd4095, 1'b1);
		send_sample(12'd1, 1'b0);
		send_sample(12'd2, 1'b1);
	endtask

	task automatic test_wraparound();
		// neighbors exactly half a turn apart do not count as a jump
		send_sample(12'd0, 1'b0);
		send_sample(12'd2048, 1'b1);
		send_sample(12'd4090, 1'b0);
		send_sample(12'd5, 1'b0);
		send_sample(12'd4094, 1'b1);
		send_sample(12'd0, 1'b0);
		send_sample(12'd2049, 1'b1);
	endtask

	task automatic test_zero_vector();
		// four quarter points cancel, with a jump in the path
		send_sample(12'd0, 1'b0);
		send_sample(12'd3072, 1'b0);
		send_sample(12'd2048, 1'b0);
		send_sample(12'd1024, 1'b1);
	endtask

	task automatic test_group_overflow();
		send_group(MAX_GROUP, 300, 20);
		send_group(MAX_GROUP + 3, 3000, 10);
		send_group(MAX_GROUP + 1, 4095, 0);
	endtask

	task automatic test_random_groups();
		int sent;
		int len, kind;
		sent = 0;
		while (sent < 1400) begin
			kind = $urandom_range(0, 9);
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(MAX_GROUP - 2, MAX_GROUP + 6)
			                                  : $urandom_range(1, 12);
			case (kind)
				0, 1: send_group(len, $urandom_range(0, 4095), 2047);
				2, 3: send_group(len, 0, 40);
				4:    send_group(len, 4095, 3);
				default: send_group(len, $urandom_range(0, 4095), $urandom_range(0, 60));
			endcase
			sent += len;
		end
	endtask

	// receiver stall: long quiet stretches, random, and periodic patterns
	always @(negedge clk) begin
		if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 2) == 0);
			2: result_stall <= ($urandom_range(0, 7) != 0);
			default: result_stall <= ~result_stall;
		endcase
	end

	// check every result transaction against the oldest prediction
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_means.size() == 0) begin
				report_mismatch("unexpected result", int'(result.mean_azimuth), -1);
			end else begin
				want = expected_means.pop_front();
				if (result.mean_azimuth !== want.mean_azimuth)
					report_mismatch("mean_azimuth", int'(result.mean_azimuth),
					                int'(want.mean_azimuth));
				if (result.wrapped !== want.wrapped)
					report_mismatch("wrapped", int'(result.wrapped), int'(want.wrapped));
				if (result.overflow !== want.overflow)
					report_mismatch("overflow", int'(result.overflow), int'(want.overflow));
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("circular_azimuth_mean_test: errors");
			$finish;
		end
	end

	initial begin
		build_trig();
		apply_reset();
		test_field_extremes();
		test_wraparound();
		test_zero_vector();
		test_group_overflow();
		test_random_groups();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (expected_means.size() > 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (error_count == 0)
			$display("circular_azimuth_mean_test: clean");
		else
			$display("circular_azimuth_mean_test: errors");
		$finish;
	end

endmodule
